// ===== hdl/sdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcm_pkg: shared types and constants of the concentric disc mapper
// Holds the arctangent table, the fixed scaling constants and the record
// that travels between the stages of the CORDIC chain.
// ----------------------------------------------------------------------------
package sdcm_pkg;

   localparam int unsigned ANGLE_WIDTH = 34;
   localparam int unsigned VEC_WIDTH   = 40;

   localparam logic [31:0] QUARTER_PI_Q30 = 32'h3243F6A8;
   localparam logic [31:0] INV_GAIN_Q30   = 32'h26DD3B6A;

   // One slot of the rotation chain
   typedef struct packed {
      logic                          valid;
      logic [1:0]                    quad;
      logic signed [VEC_WIDTH-1:0]   vec_x;
      logic signed [VEC_WIDTH-1:0]   vec_y;
      logic signed [ANGLE_WIDTH-1:0] angle;
   } stage_type;

   // atan(2^-i) in radians, 30 fractional bits
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h3243F6A8;
         5'd1:  val = 32'h1DAC6705;
         5'd2:  val = 32'h0FADBAFC;
         5'd3:  val = 32'h07F56EA6;
         5'd4:  val = 32'h03FEAB76;
         5'd5:  val = 32'h01FFD55B;
         5'd6:  val = 32'h00FFFAAA;
         5'd7:  val = 32'h007FFF55;
         5'd8:  val = 32'h003FFFEA;
         5'd9:  val = 32'h001FFFFD;
         5'd10: val = 32'h000FFFFF;
         5'd11: val = 32'h0007FFFF;
         5'd12: val = 32'h0003FFFF;
         5'd13: val = 32'h0001FFFF;
         5'd14: val = 32'h0000FFFF;
         5'd15: val = 32'h00007FFF;
         5'd16: val = 32'h00003FFF;
         5'd17: val = 32'h00001FFF;
         5'd18: val = 32'h00000FFF;
         5'd19: val = 32'h000007FF;
         5'd20: val = 32'h000003FF;
         5'd21: val = 32'h000001FF;
         5'd22: val = 32'h000000FF;
         5'd23: val = 32'h0000007F;
         5'd24: val = 32'h0000003F;
         5'd25: val = 32'h0000001F;
         5'd26: val = 32'h0000000F;
         5'd27: val = 32'h00000008;
         5'd28: val = 32'h00000004;
         5'd29: val = 32'h00000002;
         default: val = 32'h00000001;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/sdcm_divider_cell.sv =====
// ----------------------------------------------------------------------------
// sdcm_divider_cell: one restoring divide step
// Takes one quotient bit per cycle and hands the partial remainder on.
// ----------------------------------------------------------------------------
module sdcm_divider_cell #(
   parameter int unsigned NUM_WIDTH = 17,
   parameter int unsigned QUO_WIDTH = 17
) (
   input  logic                 clock,
   input  logic [NUM_WIDTH:0]   rem_in,
   input  logic [NUM_WIDTH-1:0] den_in,
   input  logic [QUO_WIDTH-1:0] quo_in,
   output logic [NUM_WIDTH:0]   rem_out,
   output logic [NUM_WIDTH-1:0] den_out,
   output logic [QUO_WIDTH-1:0] quo_out
);

   logic [NUM_WIDTH:0]   rem_ff;
   logic [NUM_WIDTH-1:0] den_ff;
   logic [QUO_WIDTH-1:0] quo_ff;
   logic [NUM_WIDTH:0]   rem_in_w;
   logic [QUO_WIDTH-1:0] quo_in_w;

   // Subtract when the divisor fits
   always_comb begin
      if (rem_in >= {1'b0, den_in}) begin
         rem_in_w = rem_in - {1'b0, den_in};
         quo_in_w = {quo_in[QUO_WIDTH-2:0], 1'b1};
      end else begin
         rem_in_w = rem_in;
         quo_in_w = {quo_in[QUO_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_w;
      den_ff <= den_in;
      quo_ff <= quo_in_w;
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

endmodule

// ===== hdl/sdcm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// sdcm_cordic_cell: one CORDIC rotation step
// Rotates the vector by atan(2^-STEP) toward the residual angle.
// ----------------------------------------------------------------------------
module sdcm_cordic_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic                clock,
   input  sdcm_pkg::stage_type stage_in,
   output sdcm_pkg::stage_type stage_out
);

   sdcm_pkg::stage_type stage_ff;
   sdcm_pkg::stage_type stage_in_w;
   logic signed [sdcm_pkg::VEC_WIDTH-1:0]   dx;
   logic signed [sdcm_pkg::VEC_WIDTH-1:0]   dy;
   logic signed [sdcm_pkg::ANGLE_WIDTH-1:0] step_angle;

   assign dx = stage_in.vec_y >>> STEP;
   assign dy = stage_in.vec_x >>> STEP;
   assign step_angle = sdcm_pkg::ANGLE_WIDTH'(sdcm_pkg::atan_entry(5'(STEP)));

   // Rotate toward zero residual
   always_comb begin
      stage_in_w = stage_in;
      if (!stage_in.angle[sdcm_pkg::ANGLE_WIDTH-1]) begin
         stage_in_w.vec_x = stage_in.vec_x - dx;
         stage_in_w.vec_y = stage_in.vec_y + dy;
         stage_in_w.angle = stage_in.angle - step_angle;
      end else begin
         stage_in_w.vec_x = stage_in.vec_x + dx;
         stage_in_w.vec_y = stage_in.vec_y - dy;
         stage_in_w.angle = stage_in.angle + step_angle;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_w;
   end

   assign stage_out = stage_ff;

endmodule

// ===== hdl/square_to_disc_concentric_map_core.sv =====
// ----------------------------------------------------------------------------
// square_to_disc_concentric_map_core: concentric square-to-disc mapper
// Maps a unit-square point to the unit disc through a divide chain and a
// CORDIC chain.
// ----------------------------------------------------------------------------
// A new point is taken every cycle; busy stays low. Each result appears on
// rsp_disc_u/rsp_disc_v with rsp_valid high for one cycle. The path from
// start holds one wedge register, FRAC_BITS + 1 divide cells at one
// quotient bit each, one angle register, one scaling register,
// ROTATION_STEPS rotation cells and one output register. Results leave in
// order; the receiver cannot stall the block.
module square_to_disc_concentric_map_core #(
   parameter int unsigned FRAC_BITS      = 16,
   parameter int unsigned ROTATION_STEPS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [FRAC_BITS:0]          req_x_coord,
   input  logic [FRAC_BITS:0]          req_y_coord,
   output logic                        rsp_valid,
   output logic signed [FRAC_BITS+1:0] rsp_disc_u,
   output logic signed [FRAC_BITS+1:0] rsp_disc_v
);

   localparam int unsigned NW = FRAC_BITS + 1;   // magnitude width
   localparam int unsigned QW = FRAC_BITS + 1;   // quotient width
   localparam int unsigned TW = FRAC_BITS + 5;   // angle width incl. sign
   localparam int unsigned VW = sdcm_pkg::VEC_WIDTH;
   localparam int unsigned AW = sdcm_pkg::ANGLE_WIDTH;
   localparam int unsigned DEPTH = QW + ROTATION_STEPS + 4;
   localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< FRAC_BITS;

   // Stage 0: clamp, fold into a wedge
   typedef struct packed {
      logic             neg;
      logic             swap;   // numerator is a
      logic [2:0]       base;   // wedge offset 0,2,4,6 / 2
      logic             center;
      logic [NW-1:0]    radius;
   } wedge_type;

   logic [DEPTH-1:0] valid_ff;
   logic signed [NW+1:0] a_in, b_in;
   logic [NW-1:0] xc, yc;
   logic [NW-1:0] num_mag, den_mag;
   wedge_type wedge_in_w;
   wedge_type wedge_ff [QW+1];
   logic [NW-1:0] num_ff, den_ff;

   assign xc = (req_x_coord > NW'(1 << FRAC_BITS)) ? NW'(1 << FRAC_BITS) : req_x_coord;
   assign yc = (req_y_coord > NW'(1 << FRAC_BITS)) ? NW'(1 << FRAC_BITS) : req_y_coord;
   assign a_in = $signed({1'b0, xc, 1'b0}) - $signed((NW+2)'(1 << FRAC_BITS));
   assign b_in = $signed({1'b0, yc, 1'b0}) - $signed((NW+2)'(1 << FRAC_BITS));

   // Pick the wedge, radius and ratio operands
   always_comb begin
      logic signed [NW+1:0] na, nb;
      na = -a_in;
      nb = -b_in;
      wedge_in_w = '0;
      num_mag = '0;
      den_mag = '0;
      if (a_in > nb) begin
         if (a_in > b_in) begin
            wedge_in_w.radius = NW'(a_in);
            wedge_in_w.base = 3'd0;
            wedge_in_w.neg = b_in[NW+1];
            num_mag = NW'(b_in[NW+1] ? nb : b_in);
            den_mag = NW'(a_in);
         end else begin
            wedge_in_w.radius = NW'(b_in);
            wedge_in_w.base = 3'd2;
            wedge_in_w.swap = 1'b1;
            wedge_in_w.neg = a_in[NW+1];
            num_mag = NW'(a_in[NW+1] ? na : a_in);
            den_mag = NW'(b_in);
         end
      end else begin
         if (a_in < b_in) begin
            wedge_in_w.radius = NW'(na);
            wedge_in_w.base = 3'd4;
            wedge_in_w.neg = !b_in[NW+1] && (b_in != 0);
            num_mag = NW'(b_in[NW+1] ? nb : b_in);
            den_mag = NW'(na);
         end else begin
            wedge_in_w.radius = NW'(nb);
            wedge_in_w.base = 3'd6;
            wedge_in_w.swap = 1'b1;
            wedge_in_w.center = (b_in == 0);
            wedge_in_w.neg = !a_in[NW+1] && (a_in != 0);
            num_mag = NW'(a_in[NW+1] ? na : a_in);
            den_mag = NW'(nb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-2:0], start};
      end
   end

   // Register the operands and carry the wedge along the divide chain
   always_ff @(posedge clock) begin
      wedge_ff[0] <= wedge_in_w;
      for (int i = 0; i < QW; i++) begin
         wedge_ff[i+1] <= wedge_ff[i];
      end
      num_ff <= num_mag;
      den_ff <= den_mag;
   end

   // Divide chain: quotient = (num << FRAC_BITS) / den, one bit per cell.
   // The numerator never exceeds the divisor, so the first cell tests the
   // numerator itself and each later cell doubles the remainder.
   logic [NW:0]   rem_w [QW+1];
   logic [NW-1:0] dd_w  [QW+1];
   logic [QW-1:0] quo_w [QW+1];

   assign rem_w[0] = {1'b0, num_ff};
   assign dd_w[0]  = den_ff;
   assign quo_w[0] = '0;

   for (genvar g = 0; g < QW; g++) begin : g_div
      logic [NW:0] rem_next;
      assign rem_next = (g == 0) ? rem_w[0] : {rem_w[g][NW-1:0], 1'b0};
      sdcm_divider_cell #(.NUM_WIDTH(NW), .QUO_WIDTH(QW)) u_cell (
         .clock   (clock),
         .rem_in  (rem_next),
         .den_in  (dd_w[g]),
         .quo_in  (quo_w[g]),
         .rem_out (rem_w[g+1]),
         .den_out (dd_w[g+1]),
         .quo_out (quo_w[g+1])
      );
   end

   // Angle, quadrant and residual
   logic signed [TW-1:0] ratio_w, t_w, tp1_w, res_w;
   logic [TW-1:0] kfull_w;
   logic [1:0] quad_ff, quad_ff2;
   logic signed [TW-1:0] res_ff;
   logic [NW-1:0] radius_ff;
   logic [FRAC_BITS:0] res_mag;
   logic [FRAC_BITS+32:0] zprod;
   logic [AW-1:0] z_ff;
   logic res_neg_ff;
   logic [NW+31:0] gprod;
   logic [VW-1:0] x0_ff;

   always_comb begin
      wedge_type w;
      w = wedge_ff[QW];
      ratio_w = w.neg ? -$signed(TW'(quo_w[QW])) : $signed(TW'(quo_w[QW]));
      if (w.center) begin
         t_w = '0;
      end else if (w.swap) begin
         t_w = $signed(TW'(w.base) <<< FRAC_BITS) - ratio_w;
      end else begin
         t_w = $signed(TW'(w.base) <<< FRAC_BITS) + ratio_w;
      end
      tp1_w = t_w + ONE_T;
      kfull_w = TW'(tp1_w >>> (FRAC_BITS + 1));
      res_w = t_w - $signed(kfull_w << (FRAC_BITS + 1));
   end

   always_ff @(posedge clock) begin
      quad_ff   <= kfull_w[1:0];
      res_ff    <= res_w;
      radius_ff <= wedge_ff[QW].radius;
   end

   assign res_mag = res_ff[TW-1] ? (FRAC_BITS+1)'(-res_ff) : (FRAC_BITS+1)'(res_ff);
   assign zprod = (FRAC_BITS+33)'(res_mag) * (FRAC_BITS+33)'(sdcm_pkg::QUARTER_PI_Q30);
   assign gprod = (NW+32)'(radius_ff) * (NW+32)'(sdcm_pkg::INV_GAIN_Q30);

   // Scale angle to radians and radius by the inverse gain
   always_ff @(posedge clock) begin
      z_ff       <= AW'(zprod >> FRAC_BITS);
      res_neg_ff <= res_ff[TW-1];
      x0_ff      <= VW'(gprod >> 30);
      quad_ff2   <= quad_ff;
   end

   // CORDIC chain
   sdcm_pkg::stage_type chain_head_w;
   sdcm_pkg::stage_type chain_w [ROTATION_STEPS+1];

   always_comb begin
      chain_head_w.valid = 1'b0;
      chain_head_w.quad  = quad_ff2;
      chain_head_w.vec_x = $signed(x0_ff);
      chain_head_w.vec_y = '0;
      chain_head_w.angle = res_neg_ff ? -$signed(z_ff) : $signed(z_ff);
   end

   assign chain_w[0] = chain_head_w;

   for (genvar s = 0; s < ROTATION_STEPS; s++) begin : g_rot
      sdcm_cordic_cell #(.STEP(s)) u_cell (
         .clock     (clock),
         .stage_in  (chain_w[s]),
         .stage_out (chain_w[s+1])
      );
   end

   // Quarter turn and saturate
   logic signed [VW-1:0] u_w, v_w;
   logic signed [FRAC_BITS+1:0] u_ff, v_ff;
   localparam logic signed [VW-1:0] ONE_V = VW'(1) <<< FRAC_BITS;
   localparam logic signed [FRAC_BITS+1:0] ONE_OUT = (FRAC_BITS+2)'(1) <<< FRAC_BITS;

   always_comb begin
      sdcm_pkg::stage_type c;
      c = chain_w[ROTATION_STEPS];
      case (c.quad)
         2'd1:    begin u_w = -c.vec_y; v_w = c.vec_x;  end
         2'd2:    begin u_w = -c.vec_x; v_w = -c.vec_y; end
         2'd3:    begin u_w = c.vec_y;  v_w = -c.vec_x; end
         default: begin u_w = c.vec_x;  v_w = c.vec_y;  end
      endcase
      if (u_w > ONE_V) u_w = ONE_V;
      if (u_w < -ONE_V) u_w = -ONE_V;
      if (v_w > ONE_V) v_w = ONE_V;
      if (v_w < -ONE_V) v_w = -ONE_V;
   end

   always_ff @(posedge clock) begin
      u_ff <= (FRAC_BITS+2)'(u_w);
      v_ff <= (FRAC_BITS+2)'(v_w);
   end

   assign busy       = 1'b0;
   assign rsp_valid  = valid_ff[DEPTH-1];
   assign rsp_disc_u = u_ff;
   assign rsp_disc_v = v_ff;

   // Checks
   a_no_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_u_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_disc_u <= ONE_OUT && rsp_disc_u >= -ONE_OUT))
      else $error("u out of range");
   a_v_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_disc_v <= ONE_OUT && rsp_disc_v >= -ONE_OUT))
      else $error("v out of range");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DEPTH-2] |=> rsp_valid)
      else $error("result lost in chain");

endmodule
